@@ sv/adsr_pkg.sv @@
// Shared types and constants for the dual ADSR envelope core.
// Used by adsr_ctrl, adsr_dp and adsr_dual_envelope_core; no dependencies.
`default_nettype none

package adsr_pkg;

    // Field widths
    localparam int LVL_W       = 16;
    localparam int ELAPSED_W   = 18;
    localparam int CFG_ADDR_W  = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;   // 33 payload bits padded to 5 bytes

    // Elapsed counter saturation point
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Level at the ends of the envelope
    localparam logic [LVL_W-1:0] LEVEL_ZERO = '0;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = LVL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ATTACK_LEN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_LEN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LEN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_LEN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_HIGH     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PEAK_LOW      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_HIGH  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SUSTAIN_LOW   = 3'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // take time step, advance elapsed, latch boundaries
        logic phase;     // select phase, operands and divider start values
        logic div_step;  // one restoring division step
        logic mul;       // scale level differences by the phase fraction
        logic fin;       // write the result into the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;  // current phase interpolates (attack, decay, release)
    } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/adsr_dual_envelope_core.sv @@
// Top level of the dual ADSR envelope core: joins controller and datapath.
// Depends on adsr_pkg, adsr_ctrl and adsr_dp.
//
//   Channel  Direction  Ports                          Contents
//   s        in         s_tvalid s_tready s_tdata      time_step
//   m        out        m_tvalid m_tready m_tdata      level_high, level_low, still_active
//   cfg      in         cfg_we cfg_addr cfg_wdata      register writes, no read-back
//
// When the phase interpolates (attack, decay, release) an accepted item passes phase
// select, 16 serial divider steps, multiply and output write, in that order. Sustain
// and finished phases skip the divider steps. Input ready returns with the result.
// One item is in flight at a time; the next is accepted once the result sits in
// the output register, which may still be waiting on m_tready.
// Reset clears the elapsed counter, all configuration registers and the output valid.
`default_nettype none

module adsr_dual_envelope_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [adsr_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] time_step
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] level_high, [31:16] level_low, [32] still_active, [39:33] zero
    output logic [adsr_pkg::OUT_TDATA_W-1:0]         m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [adsr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [adsr_pkg::LVL_W-1:0]          cfg_wdata
);

    adsr_pkg::ctrl_cmd_t cmd;
    adsr_pkg::dp_stat_t  stat;

    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    adsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    // Only one item in flight: no acceptance in the cycle after a transaction
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Never overwrite a result still waiting on the output side
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> !m_tvalid || m_tready)
        else $error("output register overwritten while stalled");

    // Past the end of release both levels are silent
    a_silent_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == '0)
        else $error("non-zero level reported after envelope end");
`endif

endmodule

`default_nettype wire

@@ sv/adsr_ctrl.sv @@
// Sequencing state machine for the dual ADSR envelope core.
// Depends on adsr_pkg for the command and status structs.
`default_nettype none

module adsr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    input  wire adsr_pkg::dp_stat_t stat,
    output adsr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [adsr_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            oval_reg, oval_next;
    logic                            fin_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = oval_reg;
    assign fin_fire = (state_reg == ST_FIN) && (!oval_reg || m_tready);

    // Decode commands from state
    always_comb
    begin
        cmd          = '0;
        cmd.load     = s_tvalid && s_tready;
        cmd.phase    = (state_reg == ST_PHASE);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.mul      = (state_reg == ST_MUL);
        cmd.fin      = fin_fire;
    end

    // Next state, step count and output valid
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oval_next  = oval_reg;
        if (m_tready)
        begin
            oval_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PHASE;
                end
            end
            ST_PHASE:
            begin
                cnt_next   = '0;
                state_next = stat.need_div ? ST_DIV : ST_MUL;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == adsr_pkg::DIV_LAST)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold until the output register is free
                if (fin_fire)
                begin
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oval_reg  <= oval_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/adsr_dp.sv @@
// Datapath of the dual ADSR envelope core: configuration registers, elapsed
// counter, phase select, serial divider, scaling multipliers and output register.
// Depends on adsr_pkg; driven by adsr_ctrl through ctrl_cmd_t.
`default_nettype none

module adsr_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [adsr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [adsr_pkg::LVL_W-1:0]         cfg_wdata,
    input  wire logic [adsr_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire adsr_pkg::ctrl_cmd_t                cmd,
    output adsr_pkg::dp_stat_t                      stat,
    output logic [adsr_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    localparam int LW = adsr_pkg::LVL_W;
    localparam int EW = adsr_pkg::ELAPSED_W;

    typedef enum logic [2:0] {
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE,
        PH_DONE
    } phase_t;

    // Configuration
    logic [LW-1:0] attack_len_reg, decay_len_reg, sustain_len_reg, release_len_reg;
    logic [LW-1:0] peak_hi_reg, peak_lo_reg, sus_hi_reg, sus_lo_reg;

    // Per-item state
    logic [EW-1:0]   elapsed_reg;
    logic [EW-1:0]   bnd_a_reg, bnd_d_reg, bnd_s_reg, bnd_r_reg;
    logic            active_reg;
    logic [LW-1:0]   len_reg, rem_reg, quo_reg;
    logic [LW-1:0]   p_hi_reg, p_lo_reg, diff_hi_reg, diff_lo_reg;
    logic            up_hi_reg, up_lo_reg;
    logic [2*LW-1:0] prod_hi_reg, prod_lo_reg;
    logic [LW-1:0]   lvl_hi_reg, lvl_lo_reg;
    logic            act_out_reg;

    logic [EW:0]     sum_next;
    logic [EW-1:0]   elapsed_next;
    logic [EW-1:0]   bnd_d_next, bnd_s_next;
    phase_t          phase_next;
    logic [EW-1:0]   start_sel;
    logic [EW-1:0]   pos_full;
    logic [LW-1:0]   len_next;
    logic [LW-1:0]   p_hi_next, q_hi_next, p_lo_next, q_lo_next;
    logic [LW:0]     rem_shift;
    logic            rem_ge;
    logic [LW-1:0]   lvl_hi_next, lvl_lo_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg  <= '0;
            decay_len_reg   <= '0;
            sustain_len_reg <= '0;
            release_len_reg <= '0;
            peak_hi_reg     <= '0;
            peak_lo_reg     <= '0;
            sus_hi_reg      <= '0;
            sus_lo_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                adsr_pkg::REG_ATTACK_LEN:   attack_len_reg  <= cfg_wdata;
                adsr_pkg::REG_DECAY_LEN:    decay_len_reg   <= cfg_wdata;
                adsr_pkg::REG_SUSTAIN_LEN:  sustain_len_reg <= cfg_wdata;
                adsr_pkg::REG_RELEASE_LEN:  release_len_reg <= cfg_wdata;
                adsr_pkg::REG_PEAK_HIGH:    peak_hi_reg     <= cfg_wdata;
                adsr_pkg::REG_PEAK_LOW:     peak_lo_reg     <= cfg_wdata;
                adsr_pkg::REG_SUSTAIN_HIGH: sus_hi_reg      <= cfg_wdata;
                adsr_pkg::REG_SUSTAIN_LOW:  sus_lo_reg      <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // Saturating elapsed sum and phase boundaries
    assign sum_next     = {1'b0, elapsed_reg} + (EW+1)'(s_tdata);
    assign elapsed_next = sum_next[EW] ? adsr_pkg::ELAPSED_MAX : sum_next[EW-1:0];
    assign bnd_d_next   = EW'(attack_len_reg) + EW'(decay_len_reg);
    assign bnd_s_next   = bnd_d_next + EW'(sustain_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else if (cmd.load)
        begin
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bnd_a_reg <= EW'(attack_len_reg);
            bnd_d_reg <= bnd_d_next;
            bnd_s_reg <= bnd_s_next;
            bnd_r_reg <= bnd_s_next + EW'(release_len_reg);
        end
    end

    // Pick phase, interpolation end points and divider operands
    always_comb
    begin
        phase_next = PH_DONE;
        start_sel  = '0;
        len_next   = '0;
        p_hi_next  = adsr_pkg::LEVEL_ZERO;
        q_hi_next  = adsr_pkg::LEVEL_ZERO;
        p_lo_next  = adsr_pkg::LEVEL_ZERO;
        q_lo_next  = adsr_pkg::LEVEL_ZERO;
        if (elapsed_reg < bnd_a_reg)
        begin
            phase_next = PH_ATTACK;
            len_next   = attack_len_reg;
            q_hi_next  = peak_hi_reg;
            q_lo_next  = peak_lo_reg;
        end
        else if (elapsed_reg < bnd_d_reg)
        begin
            phase_next = PH_DECAY;
            start_sel  = bnd_a_reg;
            len_next   = decay_len_reg;
            p_hi_next  = peak_hi_reg;
            q_hi_next  = sus_hi_reg;
            p_lo_next  = peak_lo_reg;
            q_lo_next  = sus_lo_reg;
        end
        else if (elapsed_reg < bnd_s_reg)
        begin
            phase_next = PH_SUSTAIN;
            p_hi_next  = sus_hi_reg;
            q_hi_next  = sus_hi_reg;
            p_lo_next  = sus_lo_reg;
            q_lo_next  = sus_lo_reg;
        end
        else if (elapsed_reg < bnd_r_reg)
        begin
            phase_next = PH_RELEASE;
            start_sel  = bnd_s_reg;
            len_next   = release_len_reg;
            p_hi_next  = sus_hi_reg;
            p_lo_next  = sus_lo_reg;
        end
    end

    // Position inside the phase is below its length, so it fits a level word
    assign pos_full = elapsed_reg - start_sel;

    // Interpolating phases of the current item need the divider
    assign stat.need_div = (phase_next == PH_ATTACK) || (phase_next == PH_DECAY) ||
                           (phase_next == PH_RELEASE);

    // Restoring division step: quotient of pos * 2^16 / len
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, len_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.phase)
        begin
            active_reg  <= (elapsed_reg < bnd_r_reg);
            len_reg     <= len_next;
            rem_reg     <= pos_full[LW-1:0];
            quo_reg     <= '0;
            p_hi_reg    <= p_hi_next;
            p_lo_reg    <= p_lo_next;
            up_hi_reg   <= (q_hi_next >= p_hi_next);
            up_lo_reg   <= (q_lo_next >= p_lo_next);
            diff_hi_reg <= (q_hi_next >= p_hi_next) ? q_hi_next - p_hi_next
                                                    : p_hi_next - q_hi_next;
            diff_lo_reg <= (q_lo_next >= p_lo_next) ? q_lo_next - p_lo_next
                                                    : p_lo_next - q_lo_next;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? LW'(rem_shift - {1'b0, len_reg}) : rem_shift[LW-1:0];
            quo_reg <= {quo_reg[LW-2:0], rem_ge};
        end
        if (cmd.mul)
        begin
            prod_hi_reg <= diff_hi_reg * quo_reg;
            prod_lo_reg <= diff_lo_reg * quo_reg;
        end
    end

    // Move from the start level towards the end level, truncated towards the start
    assign lvl_hi_next = up_hi_reg ? p_hi_reg + prod_hi_reg[2*LW-1:LW]
                                   : p_hi_reg - prod_hi_reg[2*LW-1:LW];
    assign lvl_lo_next = up_lo_reg ? p_lo_reg + prod_lo_reg[2*LW-1:LW]
                                   : p_lo_reg - prod_lo_reg[2*LW-1:LW];

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            lvl_hi_reg  <= lvl_hi_next;
            lvl_lo_reg  <= lvl_lo_next;
            act_out_reg <= active_reg;
        end
    end

    assign m_tdata = {(adsr_pkg::OUT_TDATA_W - 2*LW - 1)'(0), act_out_reg,
                      lvl_lo_reg, lvl_hi_reg};

endmodule

`default_nettype wire
